// File: sv/frs_pkg.sv
package frs_pkg;

  // frame counter width
  localparam int COUNT_WIDTH = 32;
  // count * 10000 needs 14 more bits
  localparam int PROD_W      = COUNT_WIDTH + 14;
  localparam int ITER_W      = $clog2(PROD_W + 1);
  localparam int RATE_ITERS  = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOOD_RATE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAIR_RATE  = 2'd3;

  localparam logic [15:0] AVG_WINDOW_RST = 16'd500;
  localparam logic [7:0]  WARMUP_RST     = 8'd5;
  localparam logic [13:0] GOOD_RATE_RST  = 14'd280;
  localparam logic [13:0] FAIR_RATE_RST  = 14'd180;

  // action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  // rate classes
  localparam logic [1:0] CLS_POOR = 2'd0;
  localparam logic [1:0] CLS_FAIR = 2'd1;
  localparam logic [1:0] CLS_GOOD = 2'd2;

  localparam logic [13:0] RATE_MAX  = 14'd9990;
  localparam logic [13:0] RATE_DVD  = 14'd10000;
  localparam logic [15:0] AVG_MAX   = 16'hFFFF;
  localparam logic [15:0] DELTA_MAX = 16'hFFFF;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_sts_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RATE = 4'b0010,
    S_AVG  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

// File: sv/frs_if.sv
interface frs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] time_ms;
  logic        reset_stats;

  modport source (output valid, action, time_ms, reset_stats, input ready);
  modport sink   (input valid, action, time_ms, reset_stats, output ready);
endinterface

interface frs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] delta_ms;
  logic [13:0] rate_tenths;
  logic [15:0] average_tenths;
  logic [13:0] minimum_tenths;
  logic [13:0] maximum_tenths;
  logic [1:0]  rate_class;

  modport source (output valid, delta_ms, rate_tenths, average_tenths, minimum_tenths,
                  maximum_tenths, rate_class, input ready);
  modport sink   (input valid, delta_ms, rate_tenths, average_tenths, minimum_tenths,
                  maximum_tenths, rate_class, output ready);
endinterface

// File: sv/frame_rate_statistics_top.sv
// Flow: an accepted frame beat runs the rate division (10000 / dt), then the average
//   division (count*10000 / elapsed), then loads the result register in S_OUT.
// A frame beat holds the block through S_OUT for the single shared serial divider;
//   a start beat is taken in S_IDLE. The next beat is accepted while a result waits.
// Reset: rst_n synchronous, active low; config returns to 500/5/280/180,
//   timestamps and count to zero, minimum to 9990, maximum to zero.
module frame_rate_statistics_top (
  input  logic                          clk,
  input  logic                          rst_n,
  frs_in_if.sink                        in_ch,
  frs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [15:0] win_r;
  logic [7:0]  warm_r;
  logic [13:0] good_r;
  logic [13:0] fair_r;

  // control and persistent statistics
  frs_pkg::state_t                 state_r;
  logic [31:0]                     last_time_r;
  logic [31:0]                     wstart_r;
  logic [frs_pkg::COUNT_WIDTH-1:0] cnt_r;
  logic [frs_pkg::COUNT_WIDTH-1:0] cnt_nxt;
  logic [13:0]                     low_r;
  logic [13:0]                     high_r;
  logic [13:0]                     low_nxt;
  logic [13:0]                     high_nxt;
  logic                            out_valid_r;

  // per-beat working registers
  logic [31:0]                 dt_r;
  logic [31:0]                 elapsed_r;
  logic [31:0]                 time_r;
  logic                        rst_r;
  logic [frs_pkg::PROD_W-1:0]  prod_r;
  logic [13:0]                 rate_r;
  logic [15:0]                 avgq_r;

  // result register
  logic [15:0] delta_o_r;
  logic [13:0] rate_o_r;
  logic [15:0] avg_o_r;
  logic [13:0] min_o_r;
  logic [13:0] max_o_r;
  logic [1:0]  cls_o_r;

  logic                        accept;
  logic [31:0]                 dt_raw;
  logic [31:0]                 dt_fix;
  logic [13:0]                 rate_sat;
  logic                        windowed;
  logic                        track;
  logic [15:0]                 avg_sel;
  logic [1:0]                  cls;
  logic                        out_free;

  frs_pkg::div_ctl_t           div_ctl;
  frs_pkg::div_sts_t           div_sts;
  logic [frs_pkg::PROD_W-1:0]  div_dividend;
  logic [31:0]                 div_divisor;
  logic [15:0]                 div_quot;

  assign in_ch.ready = (state_r == frs_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // frame interval, a zero interval counts as one millisecond
  assign dt_raw  = in_ch.time_ms - last_time_r;
  assign dt_fix  = (dt_raw == 32'd0) ? 32'd1 : dt_raw;
  // saturating frame count
  assign cnt_nxt = (&cnt_r) ? cnt_r : cnt_r + frs_pkg::COUNT_WIDTH'(1);

  // only a one-millisecond interval gives 10000
  assign rate_sat = (div_quot[13:0] > frs_pkg::RATE_MAX) ? frs_pkg::RATE_MAX : div_quot[13:0];

  // shared divider: rate first (10000 / dt), then average (count*10000 / elapsed)
  always_comb begin
    div_ctl.start = (accept && (in_ch.action == frs_pkg::ACT_FRAME))
                 || ((state_r == frs_pkg::S_RATE) && div_sts.done);
    if (state_r == frs_pkg::S_IDLE) begin
      div_ctl.iters = frs_pkg::ITER_W'(frs_pkg::RATE_ITERS);
      div_dividend  = {frs_pkg::RATE_DVD, {(frs_pkg::PROD_W-frs_pkg::RATE_ITERS){1'b0}}};
      div_divisor   = dt_fix;
    end else begin
      div_ctl.iters = frs_pkg::ITER_W'(frs_pkg::PROD_W);
      div_dividend  = prod_r;
      div_divisor   = elapsed_r;
    end
  end

  frs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  // statistics update, evaluated in S_OUT
  always_comb begin
    windowed = elapsed_r >= {16'd0, win_r};
    track    = windowed && (cnt_r > frs_pkg::COUNT_WIDTH'(warm_r));
    low_nxt  = low_r;
    high_nxt = high_r;
    avg_sel  = {2'b00, rate_r};
    if (windowed) begin
      avg_sel = avgq_r;
    end
    if (track) begin
      if (rate_r < low_r) begin
        low_nxt = rate_r;
      end
      if (rate_r > high_r) begin
        high_nxt = rate_r;
      end
    end
    if (rst_r) begin
      low_nxt  = rate_r;
      high_nxt = rate_r;
      avg_sel  = {2'b00, rate_r};
    end
    // good wins over fair when the thresholds cross
    if (rate_r >= good_r) begin
      cls = frs_pkg::CLS_GOOD;
    end else if (rate_r >= fair_r) begin
      cls = frs_pkg::CLS_FAIR;
    end else begin
      cls = frs_pkg::CLS_POOR;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= frs_pkg::AVG_WINDOW_RST;
      warm_r <= frs_pkg::WARMUP_RST;
      good_r <= frs_pkg::GOOD_RATE_RST;
      fair_r <= frs_pkg::FAIR_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        frs_pkg::REG_AVG_WINDOW: win_r  <= cfg_data[15:0];
        frs_pkg::REG_WARMUP:     warm_r <= cfg_data[7:0];
        frs_pkg::REG_GOOD_RATE:  good_r <= cfg_data[13:0];
        frs_pkg::REG_FAIR_RATE:  fair_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // sequencer and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frs_pkg::S_IDLE;
      last_time_r <= '0;
      wstart_r    <= '0;
      cnt_r       <= '0;
      low_r       <= frs_pkg::RATE_MAX;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a claimed result frees the register unless S_OUT reloads it
      if (out_valid_r && out_ch.ready && (state_r != frs_pkg::S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        frs_pkg::S_IDLE: begin
          if (accept) begin
            last_time_r <= in_ch.time_ms;
            if (in_ch.action == frs_pkg::ACT_START) begin
              wstart_r <= in_ch.time_ms;
            end else begin
              cnt_r   <= cnt_nxt;
              state_r <= frs_pkg::S_RATE;
            end
          end
        end
        frs_pkg::S_RATE: begin
          if (div_sts.done) begin
            state_r <= frs_pkg::S_AVG;
          end
        end
        frs_pkg::S_AVG: begin
          if (div_sts.done) begin
            state_r <= frs_pkg::S_OUT;
          end
        end
        frs_pkg::S_OUT: begin
          // wait here only while the previous result is still unclaimed
          if (out_free) begin
            low_r       <= low_nxt;
            high_r      <= high_nxt;
            out_valid_r <= 1'b1;
            if (rst_r) begin
              cnt_r    <= '0;
              wstart_r <= time_r;
            end
            state_r <= frs_pkg::S_IDLE;
          end
        end
        default: state_r <= frs_pkg::S_IDLE;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r      <= dt_fix;
      elapsed_r <= in_ch.time_ms - wstart_r;
      time_r    <= in_ch.time_ms;
      rst_r     <= in_ch.reset_stats;
    end
    // count is stable through the rate division
    if (state_r == frs_pkg::S_RATE) begin
      prod_r <= frs_pkg::PROD_W'(cnt_r) * frs_pkg::PROD_W'(frs_pkg::RATE_DVD);
      if (div_sts.done) begin
        rate_r <= rate_sat;
      end
    end
    if ((state_r == frs_pkg::S_AVG) && div_sts.done) begin
      // zero elapsed divides to all ones, which saturates as wanted
      avgq_r <= div_sts.ovf ? frs_pkg::AVG_MAX : div_quot;
    end
    if ((state_r == frs_pkg::S_OUT) && out_free) begin
      delta_o_r <= (dt_r[31:16] != 16'd0) ? frs_pkg::DELTA_MAX : dt_r[15:0];
      rate_o_r  <= rate_r;
      avg_o_r   <= avg_sel;
      min_o_r   <= low_nxt;
      max_o_r   <= high_nxt;
      cls_o_r   <= cls;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.delta_ms       = delta_o_r;
  assign out_ch.rate_tenths    = rate_o_r;
  assign out_ch.average_tenths = avg_o_r;
  assign out_ch.minimum_tenths = min_o_r;
  assign out_ch.maximum_tenths = max_o_r;
  assign out_ch.rate_class     = cls_o_r;

endmodule

// File: sv/frs_div.sv
// Restoring divider: dividend shifts in MSB first, one quotient bit per cycle.
module frs_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  frs_pkg::div_ctl_t        ctl,
  input  logic [frs_pkg::PROD_W-1:0] dividend,
  input  logic [31:0]              divisor,
  output frs_pkg::div_sts_t        sts,
  output logic [15:0]              quot
);

  logic [frs_pkg::PROD_W-1:0] dvd_r;
  logic [31:0]                dvs_r;
  logic [31:0]                rem_r;
  logic [31:0]                rem_nxt;
  logic [15:0]                q_r;
  logic                       ovf_r;
  logic [frs_pkg::ITER_W-1:0] cnt_r;
  logic                       done_r;
  logic [32:0]                trial;
  logic [32:0]                diff;
  logic                       ge;

  always_comb begin
    trial   = {rem_r, dvd_r[frs_pkg::PROD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        cnt_r <= ctl.iters;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - frs_pkg::ITER_W'(1);
        done_r <= (cnt_r == frs_pkg::ITER_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[frs_pkg::PROD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[14:0], ge};
      // quotient bit leaving the 16-bit window means saturation
      ovf_r <= ovf_r | q_r[15];
    end
  end

  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign quot     = q_r;

endmodule

// File: sv/frs_checker.sv
module frs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_delta,
  input logic [13:0] out_rate,
  input logic [13:0] out_min,
  input logic [13:0] out_max,
  input logic [1:0]  out_class
);

  // a frame beat occupies the block for the divisions
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == frs_pkg::ACT_FRAME) |=> !in_ready)
    else $error("frame beat did not make the block busy");

  // a new result only appears after a busy stretch
  a_rose_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a frame in progress");

  // result fields stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rate <= frs_pkg::RATE_MAX) && (out_min <= frs_pkg::RATE_MAX)
                  && (out_max <= frs_pkg::RATE_MAX) && (out_class != 2'd3)
                  && (out_delta != 16'd0))
    else $error("result field out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_rate) && $stable(out_delta))
    else $error("stalled result changed");

endmodule

bind frame_rate_statistics_top frs_checker u_frs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_delta (out_ch.delta_ms),
  .out_rate  (out_ch.rate_tenths),
  .out_min   (out_ch.minimum_tenths),
  .out_max   (out_ch.maximum_tenths),
  .out_class (out_ch.rate_class)
);
